// ===== hw/rtl/mme_pkg.sv =====
package mme_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned SUM_W   = 38;
  localparam int unsigned PROD_W  = 32;
  localparam int unsigned REG_W   = 7;
  localparam int unsigned REG_IDX_W = 2;
  // Sizes are compared at the width of the largest legal bound (1024).
  localparam int unsigned SIZE_W  = 11;
  // Wide enough for any address of a 1024 x 1024 matrix.
  localparam int unsigned ADDR_W  = 20;

  localparam logic [CMD_W-1:0] CMD_WR_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MAC  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_ROWS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS  = 2'd2;

  localparam logic [REG_W-1:0] REG_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_WR_A,
    OP_WR_B,
    OP_MAC,
    OP_REJECT
  } op_e;

  // Sizes in effect, already clamped to the parameter bounds.
  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] inner;
    logic [SIZE_W-1:0] cols;
  } size_t;

  // One classified item as it waits between front and back.
  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic [VAL_W-1:0]  value;
  } job_t;

endpackage

// ===== hw/rtl/mme_if.sv =====
interface mme_in_if import mme_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output cmd, output row_index, output col_index,
                  output value, input ready);
  modport sink   (input valid, input cmd, input row_index, input col_index,
                  input value, output ready);
endinterface

interface mme_out_if import mme_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] dot_sum;
  logic                    out_of_range;

  modport source (output valid, output dot_sum, output out_of_range, input ready);
  modport sink   (input valid, input dot_sum, input out_of_range, output ready);
endinterface

// ===== hw/rtl/mme_ram.sv =====
module mme_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mme_front.sv =====
module mme_front import mme_pkg::*; #(
  parameter int unsigned MAX_INNER = 64,
  parameter int unsigned MAX_COLS  = 64
) (
  mme_in_if.sink item_i,
  input  size_t  size_i,
  input  logic   full_i,
  output logic   push_o,
  output job_t   job_o
);

  logic [SIZE_W-1:0] row_w;
  logic [SIZE_W-1:0] col_w;
  logic              row_in_rows;
  logic              row_in_inner;
  logic              col_in_inner;
  logic              col_in_cols;

  assign item_i.ready = !full_i;
  assign push_o       = item_i.valid && !full_i;

  assign row_w = SIZE_W'(item_i.row_index);
  assign col_w = SIZE_W'(item_i.col_index);

  assign row_in_rows  = row_w < size_i.rows;
  assign row_in_inner = row_w < size_i.inner;
  assign col_in_inner = col_w < size_i.inner;
  assign col_in_cols  = col_w < size_i.cols;

  // Classify and form the base addresses; A is row-major over MAX_INNER,
  // B row-major over MAX_COLS.
  always_comb begin
    job_o.value  = item_i.value;
    job_o.a_addr = '0;
    job_o.b_addr = '0;
    job_o.op     = OP_REJECT;
    case (item_i.cmd)
      CMD_WR_A: begin
        job_o.a_addr = ADDR_W'(item_i.row_index) * ADDR_W'(MAX_INNER)
                     + ADDR_W'(item_i.col_index);
        if (row_in_rows && col_in_inner) job_o.op = OP_WR_A;
      end
      CMD_WR_B: begin
        job_o.b_addr = ADDR_W'(item_i.row_index) * ADDR_W'(MAX_COLS)
                     + ADDR_W'(item_i.col_index);
        if (row_in_inner && col_in_cols) job_o.op = OP_WR_B;
      end
      CMD_MAC: begin
        job_o.a_addr = ADDR_W'(item_i.row_index) * ADDR_W'(MAX_INNER);
        job_o.b_addr = ADDR_W'(item_i.col_index);
        if (row_in_rows && col_in_cols) job_o.op = OP_MAC;
      end
      default: job_o.op = OP_REJECT;
    endcase
  end

endmodule

// ===== hw/rtl/mme_fifo.sv =====
module mme_fifo import mme_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic full_o,
  output logic empty_o
);

  job_t       slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign job_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/mme_back.sv =====
module mme_back import mme_pkg::*; #(
  parameter int unsigned MAX_ROWS  = 64,
  parameter int unsigned MAX_INNER = 64,
  parameter int unsigned MAX_COLS  = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  size_t      size_i,
  input  job_t       job_i,
  input  logic       empty_i,
  output logic       pop_o,
  mme_out_if.source  result_o
);

  localparam int unsigned DEPTH_A = MAX_ROWS * MAX_INNER;
  localparam int unsigned DEPTH_B = MAX_INNER * MAX_COLS;
  localparam int unsigned AW_A    = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
  localparam int unsigned AW_B    = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
  localparam logic [AW_B-1:0] B_STEP = AW_B'(MAX_COLS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e                   state_q;
  logic [AW_A-1:0]          a_ptr_q;
  logic [AW_B-1:0]          b_ptr_q;
  logic [SIZE_W-1:0]        remain_q;
  logic                     rd_vld_q;
  logic                     prod_vld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q;
  logic                     out_valid_q;
  logic signed [SUM_W-1:0]  out_sum_q;
  logic                     out_oor_q;

  logic                     out_free;
  logic                     out_load;
  logic [VAL_W-1:0]         a_rdata;
  logic [VAL_W-1:0]         b_rdata;
  logic signed [PROD_W-1:0] prod_d;

  assign out_free = !out_valid_q || result_o.ready;
  assign pop_o    = (state_q == S_IDLE) && !empty_i && out_free;

  // A new result enters the output register this cycle.
  assign out_load = (pop_o && !((job_i.op == OP_MAC) && (size_i.inner != '0)))
                 || ((state_q == S_DONE) && out_free);

  mme_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH_A), .AW(AW_A)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (pop_o && (job_i.op == OP_WR_A)),
    .waddr_i (job_i.a_addr[AW_A-1:0]),
    .wdata_i (job_i.value),
    .raddr_i (a_ptr_q),
    .rdata_o (a_rdata)
  );

  mme_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH_B), .AW(AW_B)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (pop_o && (job_i.op == OP_WR_B)),
    .waddr_i (job_i.b_addr[AW_B-1:0]),
    .wdata_i (job_i.value),
    .raddr_i (b_ptr_q),
    .rdata_o (b_rdata)
  );

  assign prod_d = $signed(a_rdata) * $signed(b_rdata);

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      a_ptr_q     <= '0;
      b_ptr_q     <= '0;
      remain_q    <= '0;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_sum_q   <= '0;
      out_oor_q   <= 1'b0;
    end else begin
      if (out_valid_q && result_o.ready && !out_load) out_valid_q <= 1'b0;

      rd_vld_q   <= state_q == S_RUN;
      prod_vld_q <= rd_vld_q;
      if (prod_vld_q) acc_q <= acc_q + SUM_W'(prod_q);

      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            case (job_i.op)
              OP_WR_A, OP_WR_B: begin
                out_valid_q <= 1'b1;
                out_sum_q   <= '0;
                out_oor_q   <= 1'b0;
              end
              OP_MAC: begin
                if (size_i.inner == '0) begin
                  out_valid_q <= 1'b1;
                  out_sum_q   <= '0;
                  out_oor_q   <= 1'b0;
                end else begin
                  a_ptr_q  <= job_i.a_addr[AW_A-1:0];
                  b_ptr_q  <= job_i.b_addr[AW_B-1:0];
                  remain_q <= size_i.inner;
                  acc_q    <= '0;
                  state_q  <= S_RUN;
                end
              end
              default: begin
                out_valid_q <= 1'b1;
                out_sum_q   <= '0;
                out_oor_q   <= 1'b1;
              end
            endcase
          end
        end
        S_RUN: begin
          // One read of each matrix per cycle: A along the row, B down the column.
          a_ptr_q  <= a_ptr_q + AW_A'(1);
          b_ptr_q  <= b_ptr_q + B_STEP;
          remain_q <= remain_q - SIZE_W'(1);
          if (remain_q == SIZE_W'(1)) state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!rd_vld_q && !prod_vld_q) state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_sum_q   <= acc_q;
            out_oor_q   <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.dot_sum      = out_sum_q;
  assign result_o.out_of_range = out_oor_q;

endmodule

// ===== hw/rtl/matrix_multiply_engine.sv =====
// Matrix multiply engine: holds a left matrix A and a right matrix B of signed
// Q8.8 elements in two on-chip RAMs and returns entries of C = A x B one item
// at a time. An item with cmd 0 writes one A entry, cmd 1 one B entry, cmd 2
// returns the exact dot product of row row_index of A with column col_index of
// B over inner_used terms, as a 38-bit two's complement value with 16 fraction
// bits (wraps modulo 2^38, never saturates). Every item gives exactly one
// result; an index outside the configured sizes, or cmd 3, gives
// out_of_range = 1 with dot_sum = 0 and changes nothing. Size registers above
// their MAX_* parameter act as the parameter. Both RAMs power up undefined:
// read only entries that were written since reset. Timing: a front stage
// classifies items into a two-entry queue; the back end executes them in
// order. A write, a rejected item or a compute with zero inner size loads its
// result as it leaves the queue. Another compute goes through the cycle that
// takes it from the queue, one RAM read pair per term through a single shared
// multiply-accumulate, then read latency, product register, accumulate, a check
// that the pipeline is empty, and result load. Up to two items queue while a
// compute runs. A finished result that waits in the output register holds the
// back end: the next item stays in the queue until the result is taken.
// Configuration writes are to be issued only while no item is in flight.
module matrix_multiply_engine import mme_pkg::*; #(
  parameter int unsigned MAX_ROWS  = 64,
  parameter int unsigned MAX_INNER = 64,
  parameter int unsigned MAX_COLS  = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  mme_in_if.sink               item_i,
  mme_out_if.source            result_o
);

  logic [REG_W-1:0] rows_q;
  logic [REG_W-1:0] inner_q;
  logic [REG_W-1:0] cols_q;
  size_t            size;

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t job_in;
  job_t job_out;

  // Hold the size registers; an index beyond the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= REG_RESET;
      inner_q <= REG_RESET;
      cols_q  <= REG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROWS:  rows_q  <= cfg_data_i;
        REG_INNER: inner_q <= cfg_data_i;
        REG_COLS:  cols_q  <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // Clamp each size to the storage actually built.
  assign size.rows  = (SIZE_W'(rows_q) > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS)
                                                             : SIZE_W'(rows_q);
  assign size.inner = (SIZE_W'(inner_q) > SIZE_W'(MAX_INNER)) ? SIZE_W'(MAX_INNER)
                                                               : SIZE_W'(inner_q);
  assign size.cols  = (SIZE_W'(cols_q) > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS)
                                                             : SIZE_W'(cols_q);

  // Front: accept and classify each item.
  mme_front #(.MAX_INNER(MAX_INNER), .MAX_COLS(MAX_COLS)) u_front (
    .item_i (item_i),
    .size_i (size),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  // Queue between front and back so each side stalls on its own.
  mme_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_out),
    .full_o  (full),
    .empty_o (empty)
  );

  // Back: matrix storage, multiply-accumulate and the output register.
  mme_back #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .size_i   (size),
    .job_i    (job_out),
    .empty_i  (empty),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

// ===== hw/rtl/mme_checker.sv =====
module mme_checker import mme_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [SUM_W-1:0] dot_sum_i,
  input logic                    out_of_range_i
);

  logic [3:0] pending_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 4'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 4'd1;
    end
  end

  // A flagged item never carries a sum.
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_of_range_i |-> dot_sum_i == '0)
    else $error("flagged result with nonzero sum");

  // Every result answers an item accepted in an earlier cycle.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 4'd0)
    else $error("result without an outstanding item");

  // Queue plus either a running compute or the output register: three items.
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 4'd3)
    else $error("more items in flight than the design can hold");

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(dot_sum_i)
                                    && $stable(out_of_range_i))
    else $error("stalled result changed");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (item_i.valid),
  .in_ready_i     (item_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .dot_sum_i      (result_o.dot_sum),
  .out_of_range_i (result_o.out_of_range)
);

// ===== tb/sv/tb_matrix_multiply_engine.sv =====
`timescale 1ns / 1ps

module tb_matrix_multiply_engine;
  import mme_pkg::*;

  // Matrix bound of the instance (all three MAX_* parameters at default).
  localparam int unsigned DIM = 64;
  // cmd 3 has no name in the package; keep one here.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned MAX_REPORTS = 10;
  // Settle time covers the longest compute, with margin on top.
  localparam int unsigned SETTLE_CYCLES = DIM + 8;
  // Receiver long hold-off: start after this many results, last this long.
  localparam int unsigned HOLD_AFTER = 120;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam longint unsigned RUN_LIMIT_NS = 64'd10_000_000;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } mm_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] dot_sum;
    logic             oor;
  } c_entry_t;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_COIN,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  // Keeps its own copy of A, B and the sizes, works out each C entry as the
  // item is accepted, and compares results in order.
  class c_entry_checker;
    logic signed [VAL_W-1:0] left_q  [DIM][DIM];
    logic signed [VAL_W-1:0] right_q [DIM][DIM];
    int unsigned rows_n;
    int unsigned inner_n;
    int unsigned cols_n;
    c_entry_t    expected_c [$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      rows_n     = DIM;
      inner_n    = DIM;
      cols_n     = DIM;
      mismatches = 0;
      checked    = 0;
    endfunction

    // Sizes above the bound act as the bound.
    function void set_size(logic [REG_IDX_W-1:0] idx, int unsigned data);
      int unsigned v;
      v = (data > DIM) ? DIM : data;
      case (idx)
        REG_ROWS:  rows_n  = v;
        REG_INNER: inner_n = v;
        REG_COLS:  cols_n  = v;
        default: ;
      endcase
    endfunction

    function void apply_item(mm_item_t it);
      c_entry_t exp_c;
      longint   acc;
      exp_c.dot_sum = '0;
      exp_c.oor     = 1'b1;
      case (it.cmd)
        CMD_WR_A: begin
          if (it.row < rows_n && it.col < inner_n) begin
            left_q[it.row][it.col] = it.value;
            exp_c.oor = 1'b0;
          end
        end
        CMD_WR_B: begin
          if (it.row < inner_n && it.col < cols_n) begin
            right_q[it.row][it.col] = it.value;
            exp_c.oor = 1'b0;
          end
        end
        CMD_MAC: begin
          if (it.row < rows_n && it.col < cols_n) begin
            acc = 0;
            for (int t = 0; t < inner_n; t++)
              acc += longint'(left_q[it.row][t]) * longint'(right_q[t][it.col]);
            exp_c.dot_sum = acc[SUM_W-1:0];
            exp_c.oor     = 1'b0;
          end
        end
        default: ;
      endcase
      expected_c.push_back(exp_c);
    endfunction

    function void check_c_entry(logic [SUM_W-1:0] sum, logic oor);
      c_entry_t exp_c;
      checked++;
      if (expected_c.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: dot_sum=%0d out_of_range=%0b", $signed(sum), oor);
        return;
      end
      exp_c = expected_c.pop_front();
      if (sum !== exp_c.dot_sum) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d dot_sum: expected %0d, got %0d",
                   checked, $signed(exp_c.dot_sum), $signed(sum));
      end
      if (oor !== exp_c.oor) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d out_of_range: expected %0b, got %0b",
                   checked, exp_c.oor, oor);
      end
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index_i = REG_ROWS;
  logic [REG_W-1:0]     cfg_data_i  = REG_RESET;

  mme_in_if  item_bus ();
  mme_out_if result_bus ();

  c_entry_checker c_check;

  // Items waiting to be offered, and handshake bookkeeping.
  mm_item_t    item_backlog [$];
  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;

  // Entries already written (as seen by the item stream), so that a compute
  // never touches an entry the block holds undefined.
  bit a_written [DIM][DIM];
  bit b_written [DIM][DIM];

  matrix_multiply_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_bus),
    .result_o    (result_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Queue one item and mark the entry it writes, at the sizes now in effect.
  function void push_item(logic [CMD_W-1:0] cmd, int unsigned row, int unsigned col,
                          logic [VAL_W-1:0] value);
    mm_item_t it;
    it.cmd   = cmd;
    it.row   = row[IDX_W-1:0];
    it.col   = col[IDX_W-1:0];
    it.value = value;
    if (cmd == CMD_WR_A && row < c_check.rows_n && col < c_check.inner_n)
      a_written[row][col] = 1'b1;
    if (cmd == CMD_WR_B && row < c_check.inner_n && col < c_check.cols_n)
      b_written[row][col] = 1'b1;
    item_backlog.push_back(it);
    items_queued++;
  endfunction

  function bit pair_ready(int unsigned r, int unsigned c);
    for (int t = 0; t < c_check.inner_n; t++)
      if (!a_written[r][t] || !b_written[t][c])
        return 1'b0;
    return 1'b1;
  endfunction

  // Half the time any 6-bit index, else one from zero up to the size itself,
  // so both sides of the bound get hit.
  function int unsigned pick_index(int unsigned bound);
    int unsigned v;
    if ($urandom_range(1, 0) == 1)
      v = $urandom_range(DIM - 1, 0);
    else
      v = $urandom_range(bound, 0);
    return (v > DIM - 1) ? DIM - 1 : v;
  endfunction

  // Well-formed sequence: fill row r of A and column c of B (rewrite some
  // entries with fresh values), compute C(r,c), then a few other ready entries.
  function void push_dot_sequence();
    int unsigned r, c, r2, c2;
    r = $urandom_range(c_check.rows_n - 1, 0);
    c = $urandom_range(c_check.cols_n - 1, 0);
    for (int t = 0; t < c_check.inner_n; t++) begin
      if (!a_written[r][t] || $urandom_range(3, 0) == 0)
        push_item(CMD_WR_A, r, t, VAL_W'($urandom));
      if (!b_written[t][c] || $urandom_range(3, 0) == 0)
        push_item(CMD_WR_B, t, c, VAL_W'($urandom));
    end
    push_item(CMD_MAC, r, c, VAL_W'($urandom));
    repeat ($urandom_range(3, 0)) begin
      r2 = $urandom_range(c_check.rows_n - 1, 0);
      c2 = $urandom_range(c_check.cols_n - 1, 0);
      if (pair_ready(r2, c2))
        push_item(CMD_MAC, r2, c2, VAL_W'($urandom));
    end
  endfunction

  // Noise: any cmd, indices often out of range. A legal compute that would
  // read an unwritten entry turns into an A write.
  function void push_noise_item();
    logic [CMD_W-1:0] cmd;
    int unsigned rb, cb, r, c;
    cmd = CMD_W'($urandom_range(3, 0));
    case (cmd)
      CMD_WR_A: begin rb = c_check.rows_n;  cb = c_check.inner_n; end
      CMD_WR_B: begin rb = c_check.inner_n; cb = c_check.cols_n;  end
      default:  begin rb = c_check.rows_n;  cb = c_check.cols_n;  end
    endcase
    r = pick_index(rb);
    c = pick_index(cb);
    if (cmd == CMD_MAC && r < c_check.rows_n && c < c_check.cols_n && !pair_ready(r, c))
      cmd = CMD_WR_A;
    push_item(cmd, r, c, VAL_W'($urandom));
  endfunction

  function void push_random_items(int unsigned count);
    int unsigned start;
    start = items_queued;
    while (items_queued - start < count) begin
      if (c_check.rows_n > 0 && c_check.cols_n > 0 && $urandom_range(4, 0) != 0)
        push_dot_sequence();
      else
        push_noise_item();
    end
  endfunction

  // Raise the write enable for one register; the caller drops it at the end.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int unsigned data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= REG_W'(data);
    c_check.set_size(idx, data);
  endtask

  // Write all three sizes back to back; only call while the block is idle.
  task automatic configure(int unsigned rows, int unsigned inner, int unsigned cols);
    write_reg(REG_ROWS, rows);
    write_reg(REG_INNER, inner);
    write_reg(REG_COLS, cols);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every queued item is accepted and every result is back, then
  // give the back end time to settle.
  task automatic wait_idle();
    do
      @(posedge clk_i);
    while (items_accepted != items_queued || c_check.expected_c.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sender: offer items in bursts of random length with random gaps; hold an
  // item steady while the block stalls it.
  initial begin : item_sender
    mm_item_t    cur;
    int unsigned burst_left;
    int unsigned gap_left;
    item_bus.valid     <= 1'b0;
    item_bus.cmd       <= CMD_WR_A;
    item_bus.row_index <= '0;
    item_bus.col_index <= '0;
    item_bus.value     <= '0;
    burst_left = 0;
    gap_left   = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (item_bus.valid && item_bus.ready) begin
        c_check.apply_item(cur);
        items_accepted++;
      end
      if (item_bus.valid && !item_bus.ready) begin
        // hold the offered item
      end else if (gap_left > 0) begin
        item_bus.valid <= 1'b0;
        gap_left--;
      end else if (item_backlog.size() > 0) begin
        cur = item_backlog.pop_front();
        item_bus.valid     <= 1'b1;
        item_bus.cmd       <= cur.cmd;
        item_bus.row_index <= cur.row;
        item_bus.col_index <= cur.col;
        item_bus.value     <= cur.value;
        if (burst_left > 0)
          burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(16, 1);
          // a third of the bursts run straight into the next one
          gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
        end
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: check each accepted result; stall in a pattern that changes
  // mode now and then, and once hold off long enough to back up the input.
  initial begin : result_receiver
    stall_mode_e mode;
    int unsigned cycle_n;
    int unsigned hold_left;
    bit          hold_done;
    result_bus.ready <= 1'b0;
    mode      = STALL_NONE;
    cycle_n   = 0;
    hold_left = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (result_bus.valid && result_bus.ready)
        c_check.check_c_entry(result_bus.dot_sum, result_bus.out_of_range);
      cycle_n++;
      if (cycle_n % 97 == 0)
        mode = stall_mode_e'($urandom_range(3, 0));
      if (!hold_done && c_check.checked >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        case (mode)
          STALL_NONE:     result_bus.ready <= 1'b1;
          STALL_COIN:     result_bus.ready <= ($urandom_range(1, 0) == 1);
          STALL_PERIODIC: result_bus.ready <= (cycle_n % 5) != 0;
          default:        result_bus.ready <= ($urandom_range(4, 0) == 0);
        endcase
      end
    end
  end

  // Main sequence: reset, directed items, then random phases over several
  // size settings, each phase started only once the block has drained.
  initial begin : test_sequence
    c_check = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset sizes: corner indices, extreme values, unused cmd.
    push_item(CMD_WR_A, DIM - 1, DIM - 1, 16'h7FFF);
    push_item(CMD_WR_B, DIM - 1, DIM - 1, 16'h8000);
    push_item(CMD_UNUSED, DIM - 1, DIM - 1, 16'hFFFF);
    wait_idle();

    // Tiny matrices: largest positive and negative products, value ignored
    // on compute, and every kind of out-of-range index.
    configure(2, 1, 2);
    push_item(CMD_WR_A, 0, 0, 16'h8000);
    push_item(CMD_WR_B, 0, 0, 16'h8000);
    push_item(CMD_MAC, 0, 0, 16'hFFFF);
    push_item(CMD_WR_A, 1, 0, 16'h7FFF);
    push_item(CMD_WR_B, 0, 1, 16'h8000);
    push_item(CMD_MAC, 1, 1, 16'h0000);
    push_item(CMD_MAC, 0, 1, 16'h5555);
    push_item(CMD_MAC, 1, 0, 16'hAAAA);
    push_item(CMD_WR_A, 1, 0, 16'h0000);
    push_item(CMD_MAC, 1, 1, 16'h1234);
    push_item(CMD_WR_A, 2, 0, 16'h0101);
    push_item(CMD_WR_A, 0, 1, 16'h0202);
    push_item(CMD_WR_B, 1, 0, 16'h0303);
    push_item(CMD_WR_B, 0, 2, 16'h0404);
    push_item(CMD_MAC, 2, 0, 16'h0000);
    push_item(CMD_MAC, 0, 2, 16'h0000);
    push_item(CMD_UNUSED, 0, 0, 16'h0000);
    wait_idle();

    configure(4, 3, 5);
    push_random_items(70);
    wait_idle();

    // Rows and columns above the bound saturate; short dot product keeps
    // far corners cheap to reach.
    configure(127, 2, 100);
    push_random_items(80);
    wait_idle();

    // Full-length dot product.
    configure(1, 64, 1);
    push_random_items(140);
    wait_idle();

    // Zero sizes: rows, then inner (sums all zero), then columns.
    configure(0, 5, 3);
    push_random_items(25);
    wait_idle();
    configure(3, 0, 3);
    push_random_items(25);
    wait_idle();
    configure(5, 4, 0);
    push_random_items(25);
    wait_idle();

    configure(16, 8, 16);
    push_random_items(60);
    wait_idle();

    configure(1, 1, 1);
    push_random_items(20);
    wait_idle();

    if (c_check.mismatches == 0 && c_check.expected_c.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
